[rtl/b64url_pkg.sv]
// shared types and constants for the base64url decoder
`timescale 1ns / 1ps

package b64url_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // one closed group: decoded bits left-aligned, byte count and end flag
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        eod;
  } group_t;

endpackage

[rtl/b64url_front.sv]
// front end: classifies characters, accumulates symbols, closes groups
`timescale 1ns / 1ps

module b64url_front
  import b64url_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       accept,
  output logic       push,
  output group_t     grp
);

  logic [23:0] acc;
  logic [1:0]  slot_count;
  logic [2:0]  valid_count;

  logic        sym_ok;
  logic [5:0]  sym;
  logic [23:0] acc_next;
  logic [2:0]  vcnt_next;
  logic        close;

  always_comb begin
    sym_ok = 1'b1;
    sym    = '0;
    if (char_code inside {[8'h41:8'h5a]}) begin
      sym = 6'(char_code - 8'h41);
    end else if (char_code inside {[8'h61:8'h7a]}) begin
      sym = 6'(char_code - 8'h61 + 8'd26);
    end else if (char_code inside {[8'h30:8'h39]}) begin
      sym = 6'(char_code - 8'h30 + 8'd52);
    end else if (char_code == 8'h2d) begin
      sym = 6'd62;
    end else if (char_code == 8'h5f) begin
      sym = 6'd63;
    end else begin
      sym_ok = 1'b0;
    end
  end

  assign acc_next  = sym_ok ? {acc[17:0], sym} : acc;
  assign vcnt_next = valid_count + {2'b00, sym_ok};
  assign close     = (slot_count == 2'd3) || last_char;

  // left-align the bytes so the back end always takes the top byte
  always_comb begin
    grp.eod = last_char;
    case (vcnt_next)
      3'd4: begin
        grp.bits   = acc_next;
        grp.nbytes = 2'd3;
      end
      3'd3: begin
        grp.bits   = {acc_next[17:0], 6'b0};
        grp.nbytes = 2'd2;
      end
      3'd2: begin
        grp.bits   = {acc_next[11:0], 12'b0};
        grp.nbytes = 2'd1;
      end
      default: begin
        grp.bits   = '0;
        grp.nbytes = 2'd0;
      end
    endcase
  end

  assign push = accept && close && ((grp.nbytes != 2'd0) || last_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      slot_count  <= '0;
      valid_count <= '0;
    end else if (accept) begin
      if (close) begin
        acc         <= '0;
        slot_count  <= '0;
        valid_count <= '0;
      end else begin
        acc         <= acc_next;
        slot_count  <= slot_count + 2'd1;
        valid_count <= vcnt_next;
      end
    end
  end

  a_vcnt_le_slot: assert property (@(posedge clk) disable iff (rst)
    valid_count <= {1'b0, slot_count})
    else $error("more symbols than used positions");

endmodule

[rtl/b64url_queue.sv]
// short queue of closed groups between front and back end
`timescale 1ns / 1ps

module b64url_queue
  import b64url_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t wdata,
  input  logic   pop,
  output group_t rdata,
  output logic   empty,
  output logic   full
);

  group_t             entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QDEPTH));
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

[rtl/b64url_back.sv]
// back end: unpacks groups into one byte per output transaction
`timescale 1ns / 1ps

module b64url_back
  import b64url_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  group_t     q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       end_of_data
);

  logic [15:0] wrk_data;
  logic [1:0]  wrk_left;
  logic        wrk_eod;
  logic        load;

  // output register free or being taken this cycle
  assign load  = !out_valid || !out_stall;
  assign q_pop = load && (wrk_left == 2'd0) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wrk_left  <= '0;
    end else if (load) begin
      if (wrk_left != 2'd0) begin
        out_valid <= 1'b1;
        wrk_left  <= wrk_left - 2'd1;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        wrk_left  <= (q_data.nbytes == 2'd0) ? 2'd0 : q_data.nbytes - 2'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (wrk_left != 2'd0) begin
        data_byte   <= wrk_data[15:8];
        byte_valid  <= 1'b1;
        end_of_data <= wrk_eod && (wrk_left == 2'd1);
        wrk_data    <= {wrk_data[7:0], 8'h00};
      end else if (!q_empty) begin
        wrk_eod <= q_data.eod;
        if (q_data.nbytes == 2'd0) begin
          // end marker with no byte
          data_byte   <= 8'h00;
          byte_valid  <= 1'b0;
          end_of_data <= 1'b1;
        end else begin
          data_byte   <= q_data.bits[23:16];
          byte_valid  <= 1'b1;
          end_of_data <= q_data.eod && (q_data.nbytes == 2'd1);
          wrk_data    <= q_data.bits[15:0];
        end
      end
    end
  end

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (wrk_left == 2'd0) && !q_empty)
    else $error("group popped while bytes remain");

  a_marker_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> end_of_data)
    else $error("marker without end flag");

  a_pending_bytes: assert property (@(posedge clk) disable iff (rst)
    ((wrk_left != 2'd0) && load) |=> (out_valid && byte_valid))
    else $error("pending byte not issued");

endmodule

[rtl/base64url_decoder.sv]
// top level of the streaming base64url decoder
`timescale 1ns / 1ps

// Input channel: one character per transaction (char_code, last_char) on
// in_valid / in_stall. URL-safe alphabet characters become 6-bit symbols;
// any other byte takes a group position but adds no symbol. A group closes
// after four positions or on last_char and yields 3, 2 or 1 bytes for 4, 3
// or 2 symbols. On last_char at least one transaction is always sent; if no
// byte is available it is a marker with byte_valid low.
// Output channel: one decoded byte per transaction (data_byte, byte_valid,
// end_of_data) on out_valid / out_stall; end_of_data marks the final one.
// Throughput: one character per cycle in while in_stall is low, one byte
// per cycle out while out_stall is low. A group enters the queue at the
// edge that accepts its closing character; its first byte is registered
// once the prior group is done; the rest follow while out_stall is low.
// A four-entry group queue separates the two ends. When the receiver
// stalls, the output holds and the queue fills; in_stall rises only while
// the queue is full.
// Reset (rst, synchronous) empties the group, the queue and the output.

module base64url_decoder
  import b64url_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       end_of_data
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;
  group_t grp_in;
  group_t grp_out;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  b64url_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .last_char (last_char),
    .accept    (accept),
    .push      (push),
    .grp       (grp_in)
  );

  b64url_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (grp_in),
    .pop   (pop),
    .rdata (grp_out),
    .empty (q_empty),
    .full  (q_full)
  );

  b64url_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (grp_out),
    .q_empty     (q_empty),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .end_of_data (end_of_data)
  );

endmodule
